// ===== rtl/ptw_pkg.sv =====
// shared types, codes and helpers of the four-level page table walker
`timescale 1ns / 1ps

package ptw_pkg;

   localparam int PA_BITS         = 52;
   localparam int VA_BITS         = 48;
   localparam int PAGE_BITS       = 12;
   localparam int INDEX_BITS      = 9;
   localparam int TABLE_BITS      = PA_BITS - PAGE_BITS;
   localparam int ENTRY_ADDR_BITS = TABLE_BITS + INDEX_BITS;
   localparam int WORD_BITS       = 64;
   localparam int WINDEX_BITS     = 12;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_HUGE    = 7;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam logic REG_ROOT    = 1'b0;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_XLATE = 1'b1;

   localparam logic [1:0] FAULT_NONE        = 2'd0;
   localparam logic [1:0] FAULT_NOT_PRESENT = 2'd1;
   localparam logic [1:0] FAULT_OUTSIDE     = 2'd2;

   localparam logic [1:0] SIZE_4K = 2'd0;
   localparam logic [1:0] SIZE_2M = 2'd1;
   localparam logic [1:0] SIZE_1G = 2'd2;

   localparam logic [1:0] LVL_TOP  = 2'd0;
   localparam logic [1:0] LVL_1G   = 2'd1;
   localparam logic [1:0] LVL_2M   = 2'd2;
   localparam logic [1:0] LVL_LEAF = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   typedef struct packed {
      logic [PA_BITS-1:0] xlat_addr;
      logic [1:0]         fault_kind;
      logic [1:0]         page_size;
      logic [1:0]         fault_level;
   } rsp_type;

   function automatic logic [INDEX_BITS-1:0] level_index(input logic [VA_BITS-1:0] va,
                                                         input logic [1:0] lvl);
      logic [INDEX_BITS-1:0] idx;
      unique case (lvl)
         LVL_TOP:  idx = va[39 +: INDEX_BITS];
         LVL_1G:   idx = va[30 +: INDEX_BITS];
         LVL_2M:   idx = va[21 +: INDEX_BITS];
         default:  idx = va[12 +: INDEX_BITS];
      endcase
      return idx;
   endfunction

endpackage

// ===== rtl/ptw_ram.sv =====
// generic single-clock ram with one write port and one registered read port
`timescale 1ns / 1ps

module ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ptw_walker.sv =====
// walk sequencer: store writes, per-level entry reads and result register
`timescale 1ns / 1ps

module ptw_walker #(
   parameter int STORE_WORDS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                func,
   input  logic [63:0]                         lin_addr,
   input  logic [ptw_pkg::WINDEX_BITS-1:0]     word_index,
   input  logic [ptw_pkg::WORD_BITS-1:0]       word_data,
   input  logic [ptw_pkg::PA_BITS-1:0]         root_base,
   output logic                                ram_wr_en,
   output logic [$clog2(STORE_WORDS)-1:0]      ram_wr_addr,
   output logic [ptw_pkg::WORD_BITS-1:0]       ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(STORE_WORDS)-1:0]      ram_rd_addr,
   input  logic [ptw_pkg::WORD_BITS-1:0]       ram_rd_data,
   output logic                                rsp_valid,
   output ptw_pkg::rsp_type                    rsp
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam logic [ptw_pkg::ENTRY_ADDR_BITS-1:0] ENTRY_LIMIT =
      ptw_pkg::ENTRY_ADDR_BITS'(STORE_WORDS);
   localparam logic [20:0] WRITE_LIMIT = 21'(STORE_WORDS);

   ptw_pkg::state_type                state_ff, state_in;
   logic [1:0]                        level_ff, level_in;
   logic [ptw_pkg::VA_BITS-1:0]       va_ff, va_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   ptw_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [ptw_pkg::WORD_BITS-1:0]       entry;
   logic [ptw_pkg::TABLE_BITS-1:0]      tbl_sel;
   logic [1:0]                          lvl_sel;
   logic [ptw_pkg::VA_BITS-1:0]         va_sel;
   logic [ptw_pkg::ENTRY_ADDR_BITS-1:0] ent_addr;
   logic                                ent_in_store;
   logic                                wr_in_store;

   assign entry = ram_rd_data;

   // next entry address: root table on accept, else the table the current entry points to
   always_comb begin
      if (state_ff == ptw_pkg::ST_IDLE) begin
         tbl_sel = root_base[ptw_pkg::PA_BITS-1:ptw_pkg::PAGE_BITS];
         lvl_sel = ptw_pkg::LVL_TOP;
         va_sel  = lin_addr[ptw_pkg::VA_BITS-1:0];
      end else begin
         tbl_sel = entry[ptw_pkg::PA_BITS-1:ptw_pkg::PAGE_BITS];
         lvl_sel = level_ff + 2'd1;
         va_sel  = va_ff;
      end
   end

   assign ent_addr     = {tbl_sel, ptw_pkg::level_index(va_sel, lvl_sel)};
   assign ent_in_store = ent_addr < ENTRY_LIMIT;
   assign wr_in_store  = {9'd0, word_index} < WRITE_LIMIT;

   assign ram_wr_addr = AW'(word_index);
   assign ram_wr_data = word_data;
   assign ram_rd_addr = ent_addr[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      va_in        = va_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ptw_pkg::ST_IDLE: begin
            if (start) begin
               rsp_in = '0;
               if (func == ptw_pkg::FUNC_WRITE) begin
                  ram_wr_en    = wr_in_store;
                  rsp_valid_in = 1'b1;
               end else begin
                  va_in    = lin_addr[ptw_pkg::VA_BITS-1:0];
                  level_in = ptw_pkg::LVL_TOP;
                  if (ent_in_store) begin
                     ram_rd_en = 1'b1;
                     state_in  = ptw_pkg::ST_WALK;
                  end else begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.fault_kind = ptw_pkg::FAULT_OUTSIDE;
                  end
               end
            end
         end
         ptw_pkg::ST_WALK: begin
            rsp_in             = '0;
            rsp_in.fault_level = level_ff;
            priority if (!entry[ptw_pkg::BIT_PRESENT]) begin
               rsp_in.fault_kind = ptw_pkg::FAULT_NOT_PRESENT;
               rsp_valid_in      = 1'b1;
               state_in          = ptw_pkg::ST_IDLE;
            end else if ((level_ff == ptw_pkg::LVL_1G) && entry[ptw_pkg::BIT_HUGE]) begin
               rsp_in.xlat_addr = {entry[51:30], va_ff[29:0]};
               rsp_in.page_size = ptw_pkg::SIZE_1G;
               rsp_valid_in     = 1'b1;
               state_in         = ptw_pkg::ST_IDLE;
            end else if ((level_ff == ptw_pkg::LVL_2M) && entry[ptw_pkg::BIT_HUGE]) begin
               rsp_in.xlat_addr = {entry[51:21], va_ff[20:0]};
               rsp_in.page_size = ptw_pkg::SIZE_2M;
               rsp_valid_in     = 1'b1;
               state_in         = ptw_pkg::ST_IDLE;
            end else if (level_ff == ptw_pkg::LVL_LEAF) begin
               rsp_in.xlat_addr = {entry[51:12], va_ff[11:0]};
               rsp_in.page_size = ptw_pkg::SIZE_4K;
               rsp_valid_in     = 1'b1;
               state_in         = ptw_pkg::ST_IDLE;
            end else if (!ent_in_store) begin
               rsp_in.fault_kind  = ptw_pkg::FAULT_OUTSIDE;
               rsp_in.fault_level = lvl_sel;
               rsp_valid_in       = 1'b1;
               state_in           = ptw_pkg::ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               level_in  = lvl_sel;
            end
         end
         default: begin
            state_in = ptw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptw_pkg::ST_IDLE;
         level_ff     <= ptw_pkg::LVL_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff  <= va_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = state_ff == ptw_pkg::ST_WALK;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // no request result can show while a walk is still reading entries
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptw_pkg::ST_WALK) |-> !rsp_valid_ff)
      else $error("result strobe during walk");

   // a faulted walk reports no address and no page size
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.fault_kind != ptw_pkg::FAULT_NONE))
      |-> ((rsp_ff.xlat_addr == '0) && (rsp_ff.page_size == ptw_pkg::SIZE_4K)))
      else $error("fault result carries translation");

   // each walk cycle either finishes or descends exactly one level
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptw_pkg::ST_WALK)
      |=> ((state_ff == ptw_pkg::ST_IDLE) || (level_ff == $past(level_ff) + 2'd1)))
      else $error("walk level skipped");

   // a read is issued only on a translate accept or while descending
   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> ((state_ff == ptw_pkg::ST_WALK) || (start && func == ptw_pkg::FUNC_XLATE)))
      else $error("stray entry read");

endmodule

// ===== rtl/four_level_page_table_walk.sv =====
// top level: root table register, csr port, walk sequencer and page memory
// results: a write request strobes its result in the cycle after acceptance; a translate
//   strobes likewise if its root entry lies outside the store, else once its last entry
//   read is checked; busy stays high while entries are read, so no new request is taken
//   until a translate ends; the single page memory read port serializes the dependent level reads
// reset: control state and the root table register clear; page memory is not cleared
`timescale 1ns / 1ps

module four_level_page_table_walk #(
   parameter int STORE_WORDS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [63:0]                         req_lin_addr,
   input  logic [11:0]                         req_word_index,
   input  logic [63:0]                         req_word_data,
   output logic                                rsp_valid,
   output logic [51:0]                         rsp_xlat_addr,
   output logic [1:0]                          rsp_fault_kind,
   output logic [1:0]                          rsp_page_size,
   output logic [1:0]                          rsp_fault_level,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ptw_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ptw_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ptw_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   localparam int AW = $clog2(STORE_WORDS);

   logic [ptw_pkg::PA_BITS-1:0]   root_ff, root_in;
   logic                          csr_wr;
   logic                          csr_hit;

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [ptw_pkg::WORD_BITS-1:0] ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [ptw_pkg::WORD_BITS-1:0] ram_rd_data;
   ptw_pkg::rsp_type              rsp;

   // registers sit at 8-byte steps, only the root table exists
   assign csr_hit = paddr[3] == ptw_pkg::REG_ROOT;
   assign csr_wr  = psel && penable && pwrite && csr_hit;
   assign root_in = csr_wr ? pwdata[ptw_pkg::PA_BITS-1:0] : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = csr_hit ? ptw_pkg::CSR_DATA_BITS'(root_ff) : '0;

   ptw_walker #(
      .STORE_WORDS(STORE_WORDS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .func        (req_func),
      .lin_addr    (req_lin_addr),
      .word_index  (req_word_index),
      .word_data   (req_word_data),
      .root_base   (root_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   ptw_ram #(
      .WIDTH(ptw_pkg::WORD_BITS),
      .DEPTH(STORE_WORDS)
   ) u_page_mem (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_xlat_addr   = rsp.xlat_addr;
   assign rsp_fault_kind  = rsp.fault_kind;
   assign rsp_page_size   = rsp.page_size;
   assign rsp_fault_level = rsp.fault_level;

endmodule

// ===== verif/testbench.sv =====
// testbench of the page table walker: directed and random walks checked against its own predictor
`timescale 1ns / 1ps

module testbench;

   localparam int STORE_WORDS = 4096;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam logic [ptw_pkg::CSR_ADDR_BITS-1:0] ROOT_ADDR =
      ptw_pkg::CSR_ADDR_BITS'(ptw_pkg::REG_ROOT) << 3;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_func;
   logic [63:0] req_lin_addr;
   logic [11:0] req_word_index;
   logic [63:0] req_word_data;
   logic rsp_valid;
   logic [51:0] rsp_xlat_addr;
   logic [1:0] rsp_fault_kind;
   logic [1:0] rsp_page_size;
   logic [1:0] rsp_fault_level;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ptw_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [ptw_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [ptw_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   // predictor state
   logic [63:0] page_image [STORE_WORDS];
   bit word_written [STORE_WORDS];
   logic [51:0] root_base;
   ptw_pkg::rsp_type pending_results [$];

   int unsigned idle_pct;
   int unsigned mismatches;
   int unsigned store_writes;
   int unsigned walks;
   int unsigned root_settings;
   int unsigned walks_4k, walks_2m, walks_1g, walks_absent, walks_outside;
   int unsigned quiet_cycles;

   four_level_page_table_walk #(
      .STORE_WORDS(STORE_WORDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_lin_addr(req_lin_addr),
      .req_word_index(req_word_index),
      .req_word_data(req_word_data),
      .rsp_valid(rsp_valid),
      .rsp_xlat_addr(rsp_xlat_addr),
      .rsp_fault_kind(rsp_fault_kind),
      .rsp_page_size(rsp_page_size),
      .rsp_fault_level(rsp_fault_level),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // walks the predictor's copy of the store the way the block should
   function automatic ptw_pkg::rsp_type walk_result(input logic [63:0] va);
      ptw_pkg::rsp_type r;
      logic [63:0] table_pa;
      logic [63:0] entry;
      logic [63:0] word_addr;
      logic [63:0] span;
      logic [63:0] full;
      int shift;
      r = '0;
      table_pa = {12'b0, root_base};
      for (int lvl = 0; lvl < 4; lvl++) begin
         shift = 39 - 9 * lvl;
         r.fault_level = 2'(lvl);
         word_addr = ((table_pa & ADDR_MASK) >> 3) + ((va >> shift) & 64'h1FF);
         if (word_addr >= STORE_WORDS) begin
            r.fault_kind = ptw_pkg::FAULT_OUTSIDE;
            return r;
         end
         entry = page_image[word_addr];
         if (!entry[ptw_pkg::BIT_PRESENT]) begin
            r.fault_kind = ptw_pkg::FAULT_NOT_PRESENT;
            return r;
         end
         if ((lvl == ptw_pkg::LVL_1G || lvl == ptw_pkg::LVL_2M) && entry[ptw_pkg::BIT_HUGE]) begin
            span = (64'd1 << shift) - 64'd1;
            full = (entry & ADDR_MASK & ~span) | (va & span);
            r.xlat_addr = full[51:0];
            r.page_size = (lvl == ptw_pkg::LVL_1G) ? ptw_pkg::SIZE_1G : ptw_pkg::SIZE_2M;
            return r;
         end
         if (lvl == ptw_pkg::LVL_LEAF) begin
            full = (entry & ADDR_MASK) | (va & 64'hFFF);
            r.xlat_addr = full[51:0];
            r.page_size = ptw_pkg::SIZE_4K;
            return r;
         end
         table_pa = entry & ADDR_MASK;
      end
      return r;
   endfunction

   // builds a random address whose walk only reads written words; on failure
   // names a word of the table that has nothing written yet
   function automatic bit pick_reachable_va(output logic [63:0] va, output logic [11:0] stuck);
      logic [63:0] table_pa;
      logic [63:0] base_word;
      logic [63:0] entry;
      int unsigned cands [$];
      int unsigned idx;
      int shift;
      va = {$urandom, $urandom};
      stuck = '0;
      table_pa = {12'b0, root_base};
      for (int lvl = 0; lvl < 4; lvl++) begin
         shift = 39 - 9 * lvl;
         base_word = (table_pa & ADDR_MASK) >> 3;
         cands.delete();
         for (int unsigned i = 0; i < 512; i++)
            if (base_word + i >= STORE_WORDS || word_written[base_word + i])
               cands.push_back(i);
         if (cands.size() == 0) begin
            stuck = 12'(base_word + $urandom_range(511));
            return 1'b0;
         end
         idx = cands[$urandom_range(cands.size() - 1)];
         va[shift +: 9] = idx[8:0];
         if (base_word + idx >= STORE_WORDS)
            return 1'b1;
         entry = page_image[base_word + idx];
         if (!entry[ptw_pkg::BIT_PRESENT] || lvl == ptw_pkg::LVL_LEAF)
            return 1'b1;
         if ((lvl == ptw_pkg::LVL_1G || lvl == ptw_pkg::LVL_2M) && entry[ptw_pkg::BIT_HUGE])
            return 1'b1;
         table_pa = entry & ADDR_MASK;
      end
      return 1'b1;
   endfunction

   // mostly well-formed entries pointing at table pages inside the store
   function automatic logic [63:0] random_entry();
      logic [63:0] d;
      int unsigned pick;
      d = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 65) begin
         d[51:12] = 40'($urandom_range(7));
         d[ptw_pkg::BIT_PRESENT] = 1'b1;
         d[ptw_pkg::BIT_HUGE] = ($urandom_range(3) == 0);
      end else if (pick < 75) begin
         d[ptw_pkg::BIT_PRESENT] = 1'b1;
      end else if (pick < 85) begin
         d[ptw_pkg::BIT_PRESENT] = 1'b0;
      end
      return d;
   endfunction

   function automatic logic [63:0] make_va(input int unsigned i0, input int unsigned i1,
                                           input int unsigned i2, input int unsigned i3,
                                           input logic [11:0] off);
      logic [63:0] va;
      va = {$urandom, $urandom};
      va[47:39] = i0[8:0];
      va[38:30] = i1[8:0];
      va[29:21] = i2[8:0];
      va[20:12] = i3[8:0];
      va[11:0] = off;
      return va;
   endfunction

   task automatic send_req(input logic func, input logic [63:0] va,
                           input logic [11:0] idx, input logic [63:0] data);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_lin_addr <= va;
      req_word_index <= idx;
      req_word_data <= data;
      do @(posedge clock); while (busy);
      if (func == ptw_pkg::FUNC_WRITE) begin
         // word index range matches the store size
         page_image[idx] = data;
         word_written[idx] = 1'b1;
         pending_results.push_back('0);
         store_writes++;
      end else begin
         pending_results.push_back(walk_result(va));
         walks++;
      end
   endtask

   task automatic write_word(input logic [11:0] idx, input logic [63:0] data);
      send_req(ptw_pkg::FUNC_WRITE, {$urandom, $urandom}, idx, data);
   endtask

   task automatic translate_va(input logic [63:0] va);
      send_req(ptw_pkg::FUNC_XLATE, va, 12'($urandom), {$urandom, $urandom});
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
   endtask

   task automatic set_root(input logic [63:0] value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ROOT_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      root_base = value[51:0];
      root_settings++;
   endtask

   task automatic test_basic_walks();
      // root table at 0x0000, then level tables at 0x1000, 0x2000, 0x3000
      write_word(12'd0, 64'h0000_0000_0000_1001);
      write_word(12'd512, 64'h0000_0000_0000_2001);
      write_word(12'd1024, 64'h0000_0000_0000_3001);
      write_word(12'd1536, 64'hFFFF_FFFF_FFFF_F001);
      translate_va(make_va(0, 0, 0, 0, 12'hFFF));
      // 1 GiB page at the top of the address range
      write_word(12'd1023, 64'h800F_FFFF_C000_0081);
      translate_va(make_va(0, 511, $urandom_range(511), $urandom_range(511), 12'($urandom)));
      write_word(12'd1535, 64'h000F_FFFF_FFE0_0081);
      translate_va(make_va(0, 0, 511, $urandom_range(511), 12'($urandom)));
      // leaf entry with everything but the present bit
      write_word(12'd2047, 64'hFFFF_FFFF_FFFF_FFFE);
      translate_va(make_va(0, 0, 0, 511, 12'($urandom)));
   endtask

   task automatic test_ignored_huge_bits();
      write_word(12'd511, 64'h0000_0000_0000_1081);
      translate_va(make_va(511, 0, 0, 0, 12'($urandom)));
      write_word(12'd1537, 64'h0000_0000_ABCD_E081);
      translate_va(make_va(0, 0, 0, 1, 12'($urandom)));
   endtask

   task automatic test_fault_paths();
      write_word(12'd1, 64'h0);
      translate_va(make_va(1, $urandom_range(511), $urandom_range(511),
                           $urandom_range(511), 12'($urandom)));
      write_word(12'd2, 64'h000F_FFFF_FFFF_F001);
      translate_va(make_va(2, $urandom_range(511), $urandom_range(511),
                           $urandom_range(511), 12'($urandom)));
      // next table just past the end of the store
      write_word(12'd514, 64'h0000_0000_0000_8001);
      translate_va(make_va(0, 2, $urandom_range(511), $urandom_range(511), 12'($urandom)));
      write_word(12'd1025, 64'h0000_0000_0000_8001);
      translate_va(make_va(0, 0, 1, $urandom_range(511), 12'($urandom)));
   endtask

   task automatic test_root_extremes();
      write_word(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
      set_root(64'hFFFF_FFFF_FFFF_FFFF);
      translate_va({$urandom, $urandom});
      // low bits of the root are dropped, so this is the last page of the store
      set_root(64'h0000_0000_0000_7FFF);
      translate_va(make_va(511, $urandom_range(511), $urandom_range(511),
                           $urandom_range(511), 12'($urandom)));
   endtask

   task automatic run_phase(input logic [63:0] root, input int unsigned count,
                            input int unsigned idle);
      logic [63:0] va;
      logic [11:0] stuck;
      set_root(root);
      idle_pct = idle;
      repeat (count) begin
         if ($urandom_range(99) < 35)
            write_word(12'($urandom_range(4095)), random_entry());
         else if (pick_reachable_va(va, stuck))
            translate_va(va);
         else
            write_word(stuck, random_entry());
      end
   endtask

   task automatic test_random_walks();
      logic [63:0] v;
      run_phase(64'h0, 300, 19);
      v = {$urandom, $urandom};
      v[51:12] = 40'h3;
      run_phase(v, 250, 0);
      v = {$urandom, $urandom};
      v[51:12] = 40'($urandom_range(7));
      run_phase(v, 250, 19);
      run_phase({$urandom, $urandom}, 60, 19);
      v = {$urandom, $urandom};
      v[51:0] = 52'h7FFF;
      run_phase(v, 200, 19);
   endtask

   always @(posedge clock) begin
      ptw_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_xlat_addr !== want.xlat_addr) begin
               $error("xlat_addr: expected %h, got %h", want.xlat_addr, rsp_xlat_addr);
               mismatches++;
            end
            if (rsp_fault_kind !== want.fault_kind) begin
               $error("fault_kind: expected %0d, got %0d", want.fault_kind, rsp_fault_kind);
               mismatches++;
            end
            if (rsp_page_size !== want.page_size) begin
               $error("page_size: expected %0d, got %0d", want.page_size, rsp_page_size);
               mismatches++;
            end
            if (rsp_fault_level !== want.fault_level) begin
               $error("fault_level: expected %0d, got %0d", want.fault_level, rsp_fault_level);
               mismatches++;
            end
            if (want.fault_kind == ptw_pkg::FAULT_OUTSIDE)
               walks_outside++;
            else if (want.fault_kind == ptw_pkg::FAULT_NOT_PRESENT)
               walks_absent++;
            else if (want.page_size == ptw_pkg::SIZE_1G)
               walks_1g++;
            else if (want.page_size == ptw_pkg::SIZE_2M)
               walks_2m++;
            else if (want.fault_level == ptw_pkg::LVL_LEAF)
               walks_4k++;
         end
      end
   end

   // ends the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= ptw_pkg::FUNC_WRITE;
      req_lin_addr <= '0;
      req_word_index <= '0;
      req_word_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      root_base = '0;
      idle_pct = 19;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_walks();
      test_ignored_huge_bits();
      test_fault_paths();
      test_root_extremes();
      test_random_walks();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d store writes and %0d walks under %0d root table settings",
               store_writes, walks, root_settings);
      $display("walk outcomes: %0d 4K, %0d 2M, %0d 1G, %0d not present, %0d outside store",
               walks_4k, walks_2m, walks_1g, walks_absent, walks_outside);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
